// ===== rtl/core/pec_pkg.sv =====
// Shared types and constants of the polygon edge crossing test.
// No dependencies.
`default_nettype none
package pec_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_XX = 3'd0;
  localparam logic [2:0] CFG_XY = 3'd1;
  localparam logic [2:0] CFG_TX = 3'd2;
  localparam logic [2:0] CFG_YX = 3'd3;
  localparam logic [2:0] CFG_YY = 3'd4;
  localparam logic [2:0] CFG_TY = 3'd5;

  // One vertex request as it travels from front to back
  typedef struct packed {
    logic               sel;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } vertex_t;

endpackage
`default_nettype wire

// ===== rtl/core/pec_front.sv =====
// Front end: configuration registers, input handshake and affine transform.
// Depends on pec_pkg.
`default_nettype none
module pec_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_polygon_select,
  input  wire logic signed [31:0] in_vertex_x,
  input  wire logic signed [31:0] in_vertex_y,
  input  wire logic               in_last_vertex,
  output logic                    q_push,
  output pec_pkg::vertex_t        q_data,
  input  wire logic               q_full
);
  import pec_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
  localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

  fstate_t            state_r;
  logic [2:0]         step_r;
  logic signed [31:0] xx_r, xy_r, tx_r, yx_r, yy_r, ty_r;
  logic               sel_r, last_r;
  logic signed [31:0] x_r, y_r, xo_r, yo_r;
  logic signed [63:0] prod_r;
  logic signed [64:0] acc_r;
  logic signed [31:0] op_a, op_b, c_sel;
  logic signed [63:0] mul_res;
  logic signed [64:0] acc_shift;
  logic signed [49:0] aff_sum;
  logic signed [31:0] aff_sat;
  logic               accept;

  assign in_ready = (state_r == F_IDLE);
  assign accept   = in_valid && in_ready;

  // Shared multiplier operand select
  always_comb begin
    case (step_r)
      3'd0:    begin op_a = xx_r; op_b = x_r; end
      3'd1:    begin op_a = xy_r; op_b = y_r; end
      3'd2:    begin op_a = yx_r; op_b = x_r; end
      3'd3:    begin op_a = yy_r; op_b = y_r; end
      default: begin op_a = '0;   op_b = '0;  end
    endcase
  end
  assign mul_res = op_a * op_b;

  // Floor shift, translation and saturation
  assign acc_shift = acc_r >>> 16;
  assign c_sel     = (step_r == 3'd3) ? tx_r : ty_r;
  assign aff_sum   = $signed(acc_shift[48:0]) + c_sel;
  always_comb begin
    if (aff_sum > SAT_HI)      aff_sat = SAT_HI[31:0];
    else if (aff_sum < SAT_LO) aff_sat = SAT_LO[31:0];
    else                       aff_sat = aff_sum[31:0];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xx_r <= 32'sd65536; xy_r <= '0; tx_r <= '0;
      yx_r <= '0; yy_r <= 32'sd65536; ty_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_XX:  xx_r <= cfg_wdata;
        CFG_XY:  xy_r <= cfg_wdata;
        CFG_TX:  tx_r <= cfg_wdata;
        CFG_YX:  yx_r <= cfg_wdata;
        CFG_YY:  yy_r <= cfg_wdata;
        CFG_TY:  ty_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: if (accept) begin
          step_r  <= '0;
          state_r <= in_polygon_select ? F_MUL : F_PUSH;
        end
        F_MUL: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd5) state_r <= F_PUSH;
        end
        F_PUSH: if (!q_full) state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      sel_r  <= in_polygon_select;
      last_r <= in_last_vertex;
      x_r    <= in_vertex_x;
      y_r    <= in_vertex_y;
    end
    if (state_r == F_MUL) begin
      prod_r <= mul_res;
      case (step_r)
        3'd1: acc_r <= {prod_r[63], prod_r};
        3'd2: acc_r <= acc_r + {prod_r[63], prod_r};
        3'd3: begin
          xo_r  <= aff_sat;
          acc_r <= {prod_r[63], prod_r};
        end
        3'd4: acc_r <= acc_r + {prod_r[63], prod_r};
        3'd5: yo_r  <= aff_sat;
        default: ;
      endcase
    end
  end

  assign q_push      = (state_r == F_PUSH) && !q_full;
  assign q_data.sel  = sel_r;
  assign q_data.x    = sel_r ? xo_r : x_r;
  assign q_data.y    = sel_r ? yo_r : y_r;
  assign q_data.last = last_r;

endmodule
`default_nettype wire

// ===== rtl/core/pec_fifo.sv =====
// Two-entry queue of vertex requests between front and back.
// Depends on pec_pkg.
`default_nettype none
module pec_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  pec_pkg::vertex_t       wdata,
  output logic                   full,
  input  wire logic              pop,
  output pec_pkg::vertex_t       rdata,
  output logic                   empty
);
  import pec_pkg::*;

  vertex_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pec_back.sv =====
// Back end: vertex stores, edge pair sequencer with one shared multiplier,
// and the result register. Depends on pec_pkg.
`default_nettype none
module pec_back #(
  parameter int MAX_VERTICES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  pec_pkg::vertex_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic             out_overflow
);
  import pec_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_VERTICES);

  typedef enum logic [7:0] {
    B_IDLE = 8'b00000001,
    B_RD0  = 8'b00000010,
    B_RD1  = 8'b00000100,
    B_RD2  = 8'b00001000,
    B_MUL  = 8'b00010000,
    B_EVAL = 8'b00100000,
    B_TEST = 8'b01000000,
    B_DONE = 8'b10000000
  } bstate_t;

  function automatic logic signed [32:0] ext33(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  bstate_t            state_r;
  logic [63:0]        own_mem [MAX_VERTICES];
  logic [63:0]        oth_mem [MAX_VERTICES];
  logic [63:0]        own_rd_r, oth_rd_r;
  logic [IW-1:0]      own_raddr, oth_raddr;
  logic [CW-1:0]      own_cnt_r, oth_cnt_r;
  logic               own_over_r, own_closed_r, ovf_seen_r;
  logic [IW-1:0]      i_r, j_r;
  logic [IW-1:0]      i1, j1;
  logic [2:0]         k_r;
  logic signed [31:0] pix_r, piy_r, pjx_r, pjy_r;
  logic signed [32:0] ax_r, ay_r, bx_r, by_r, rx_r, ry_r;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mul_res;
  logic signed [65:0] prod_r [6];
  logic signed [66:0] d_r, n1_r, n2_r;
  logic signed [67:0] e1, e2;
  logic               hit_r, pair_hit, u1, u2;
  logic               last_pair;
  logic [CW-1:0]      own_eff, oth_new;
  logic               out_valid_r, out_hit_r, out_ovf_r;

  assign q_pop = (state_r == B_IDLE) && !q_empty;

  // Wrapped successor indexes
  assign i1 = ({1'b0, i_r} == CW'(own_cnt_r - 1'b1)) ? '0 : IW'(i_r + 1'b1);
  assign j1 = ({1'b0, j_r} == CW'(oth_cnt_r - 1'b1)) ? '0 : IW'(j_r + 1'b1);
  assign own_raddr = (state_r == B_RD1) ? i1 : i_r;
  assign oth_raddr = (state_r == B_RD1) ? j1 : j_r;

  // Store write addressing
  assign own_eff = own_closed_r ? '0 : own_cnt_r;
  assign oth_new = (oth_cnt_r < MAXC) ? CW'(oth_cnt_r + 1'b1) : oth_cnt_r;

  // Vertex memories
  always_ff @(posedge clk) begin
    if (q_pop && !q_data.sel && own_eff < MAXC)
      own_mem[own_eff[IW-1:0]] <= {q_data.x, q_data.y};
    if (q_pop && q_data.sel && oth_cnt_r < MAXC)
      oth_mem[oth_cnt_r[IW-1:0]] <= {q_data.x, q_data.y};
    own_rd_r <= own_mem[own_raddr];
    oth_rd_r <= oth_mem[oth_raddr];
  end

  // Shared multiplier
  always_comb begin
    case (k_r)
      3'd0:    begin ma = ay_r; mb = bx_r; end
      3'd1:    begin ma = ax_r; mb = by_r; end
      3'd2:    begin ma = ry_r; mb = bx_r; end
      3'd3:    begin ma = rx_r; mb = by_r; end
      3'd4:    begin ma = ry_r; mb = ax_r; end
      default: begin ma = rx_r; mb = ay_r; end
    endcase
  end
  assign mul_res = ma * mb;

  // Half-open range checks on the cross products
  assign e1 = {n1_r[66], n1_r} - {d_r[66], d_r};
  assign e2 = {n2_r[66], n2_r} - {d_r[66], d_r};
  always_comb begin
    if (!d_r[66]) begin
      u1 = !n1_r[66] && e1[67];
      u2 = !n2_r[66] && e2[67];
    end else begin
      u1 = (n1_r[66] || n1_r == '0) && !e1[67] && (e1 != '0);
      u2 = (n2_r[66] || n2_r == '0) && !e2[67] && (e2 != '0);
    end
  end
  assign pair_hit  = (d_r != '0) && u1 && u2;
  assign last_pair = ({1'b0, i_r} == CW'(own_cnt_r - 1'b1)) &&
                     ({1'b0, j_r} == CW'(oth_cnt_r - 1'b1));

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      own_cnt_r    <= '0;
      oth_cnt_r    <= '0;
      own_over_r   <= 1'b0;
      own_closed_r <= 1'b0;
      ovf_seen_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      k_r          <= '0;
      i_r          <= '0;
      j_r          <= '0;
      hit_r        <= 1'b0;
    end else begin
      // Result valid: load on a new result, drop once taken
      if (state_r == B_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready)                    out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: if (q_pop) begin
          if (!q_data.sel) begin
            if (own_eff < MAXC) own_cnt_r <= CW'(own_eff + 1'b1);
            else                own_cnt_r <= own_eff;
            own_over_r   <= (own_closed_r ? 1'b0 : own_over_r) || (own_eff >= MAXC);
            own_closed_r <= q_data.last;
          end else begin
            oth_cnt_r <= oth_new;
            if (oth_cnt_r >= MAXC) ovf_seen_r <= 1'b1;
            if (q_data.last) begin
              i_r   <= '0;
              j_r   <= '0;
              hit_r <= 1'b0;
              if (own_cnt_r == '0 || oth_new == '0) state_r <= B_DONE;
              else                                  state_r <= B_RD0;
            end
          end
        end
        B_RD0: state_r <= B_RD1;
        B_RD1: state_r <= B_RD2;
        B_RD2: begin
          k_r     <= '0;
          state_r <= B_MUL;
        end
        B_MUL: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd5) state_r <= B_EVAL;
        end
        B_EVAL: state_r <= B_TEST;
        B_TEST: begin
          if (pair_hit) begin
            hit_r   <= 1'b1;
            state_r <= B_DONE;
          end else if (last_pair) begin
            state_r <= B_DONE;
          end else begin
            state_r <= B_RD0;
            if (j1 == '0) begin
              j_r <= '0;
              i_r <= IW'(i_r + 1'b1);
            end else begin
              j_r <= j1;
            end
          end
        end
        B_DONE: if (!out_valid_r || out_ready) begin
          oth_cnt_r   <= '0;
          ovf_seen_r  <= 1'b0;
          state_r     <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // Pair datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_RD1: begin
        pix_r <= own_rd_r[63:32]; piy_r <= own_rd_r[31:0];
        pjx_r <= oth_rd_r[63:32]; pjy_r <= oth_rd_r[31:0];
      end
      B_RD2: begin
        ax_r <= ext33(own_rd_r[63:32]) - ext33(pix_r);
        ay_r <= ext33(own_rd_r[31:0])  - ext33(piy_r);
        bx_r <= ext33(oth_rd_r[63:32]) - ext33(pjx_r);
        by_r <= ext33(oth_rd_r[31:0])  - ext33(pjy_r);
        rx_r <= ext33(pjx_r) - ext33(pix_r);
        ry_r <= ext33(pjy_r) - ext33(piy_r);
      end
      B_MUL:  prod_r[k_r] <= mul_res;
      B_EVAL: begin
        d_r  <= {prod_r[0][65], prod_r[0]} - {prod_r[1][65], prod_r[1]};
        n1_r <= {prod_r[2][65], prod_r[2]} - {prod_r[3][65], prod_r[3]};
        n2_r <= {prod_r[4][65], prod_r[4]} - {prod_r[5][65], prod_r[5]};
      end
      B_DONE: if (!out_valid_r || out_ready) begin
        out_hit_r <= hit_r;
        out_ovf_r <= own_over_r || ovf_seen_r;
      end
      default: ;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_overflow = out_ovf_r;

endmodule
`default_nettype wire

// ===== rtl/core/polygon_edge_crossing_test.sv =====
// Top level of the polygon edge crossing test.
// Depends on pec_pkg, pec_front, pec_fifo and pec_back.
//
// Vertices arrive on the in_ channel (valid/ready), own polygon with
// in_polygon_select low, other polygon with it high; in_last_vertex closes a
// polygon. Other vertices go through the cfg_ affine transform, which the
// user must write only while idle; the block does not check. The last other
// vertex starts the test of every own edge against every other edge; one
// request with hit and overflow leaves on the out_ channel (valid/ready).
// The front takes a new vertex only once the last one is pushed; other
// vertices pass the front's shared 32x32 multiplier, own vertices do not.
// The test steps through edge pairs (two memory reads, six products on one shared
// multiplier, two compare steps), up to own_count * other_count pairs, and
// stops at the first crossing. A two-entry queue lets the front take
// vertices while the back tests. The result register holds while out_ready
// is low; the back then waits and the queue fills before in_ready drops.
// Reset clears counts, flags and the transform to identity; vertex stores
// are not cleared, only counted.
`default_nettype none
module polygon_edge_crossing_test #(
  parameter int MAX_VERTICES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_polygon_select,
  input  wire logic signed [31:0] in_vertex_x,
  input  wire logic signed [31:0] in_vertex_y,
  input  wire logic               in_last_vertex,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_hit,
  output logic                    out_overflow
);
  import pec_pkg::*;

  vertex_t push_data, pop_data;
  logic    push, full, pop, empty;

  pec_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_polygon_select, .in_vertex_x, .in_vertex_y,
    .in_last_vertex,
    .q_push (push), .q_data (push_data), .q_full (full)
  );

  pec_fifo u_fifo (
    .clk, .rst_n,
    .push (push), .wdata (push_data), .full (full),
    .pop (pop), .rdata (pop_data), .empty (empty)
  );

  pec_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk, .rst_n,
    .q_empty (empty), .q_data (pop_data), .q_pop (pop),
    .out_valid, .out_ready, .out_hit, .out_overflow
  );

endmodule
`default_nettype wire

// ===== test/polygon_edge_crossing_test_tb.sv =====
// Self-checking testbench for polygon_edge_crossing_test: vertex streams with
// random handshake pressure, a scoreboard that predicts hit and overflow.
// Depends on pec_pkg and the polygon_edge_crossing_test RTL.
`timescale 1ns / 100ps

// Expected crossing results, predicted from the vertex stream
class crossing_scoreboard;
  localparam int NV = 16;

  logic signed [31:0] xform [6];
  longint own_x [NV], own_y [NV], oth_x [NV], oth_y [NV];
  int     own_n, oth_n;
  bit     own_over, oth_over, own_closed;
  bit     exp_hit [$];
  bit     exp_ovf [$];
  int     errors;

  function new();
    xform[pec_pkg::CFG_XX] = 32'sd65536;
    xform[pec_pkg::CFG_XY] = 0;
    xform[pec_pkg::CFG_TX] = 0;
    xform[pec_pkg::CFG_YX] = 0;
    xform[pec_pkg::CFG_YY] = 32'sd65536;
    xform[pec_pkg::CFG_TY] = 0;
    own_n = 0; oth_n = 0; own_over = 0; oth_over = 0; own_closed = 0; errors = 0;
  endfunction

  function void set_reg(int idx, logic [31:0] v);
    xform[idx] = v;
  endfunction

  function int pending();
    return exp_hit.size();
  endfunction

  // Q16.16 affine row: floor((a*x + b*y) / 2^16) + c, saturated to 32 bits
  function longint map_row(logic signed [31:0] a, logic signed [31:0] b,
                           logic signed [31:0] c, logic signed [31:0] x,
                           logic signed [31:0] y);
    logic signed [65:0] aw, bw, xw, yw, s;
    aw = a; bw = b; xw = x; yw = y;
    s = ((aw * xw + bw * yw) >>> 16) + 66'(c);
    if (s > 66'sd2147483647) return 64'sd2147483647;
    if (s < -66'sd2147483648) return -64'sd2147483648;
    return longint'(s);
  endfunction

  function bit in_unit(logic signed [69:0] n, logic signed [69:0] d);
    if (d > 0) return n >= 0 && n < d;
    return n <= 0 && n > d;
  endfunction

  function bit edges_cross();
    logic signed [69:0] ax, ay, bx, by, rx, ry, d, n1, n2;
    int i1, j1;
    for (int i = 0; i < own_n; i++) begin
      i1 = (i + 1) % own_n;
      ax = own_x[i1] - own_x[i];
      ay = own_y[i1] - own_y[i];
      for (int j = 0; j < oth_n; j++) begin
        j1 = (j + 1) % oth_n;
        bx = oth_x[j1] - oth_x[j];
        by = oth_y[j1] - oth_y[j];
        rx = oth_x[j] - own_x[i];
        ry = oth_y[j] - own_y[i];
        d  = ay * bx - ax * by;
        n1 = ry * bx - rx * by;
        n2 = ry * ax - rx * ay;
        if (d != 0 && in_unit(n1, d) && in_unit(n2, d)) return 1;
      end
    end
    return 0;
  endfunction

  // Accepted vertex request
  function void note_vertex(bit sel, logic signed [31:0] x, logic signed [31:0] y,
                            bit last);
    if (!sel) begin
      if (own_closed) begin
        own_n = 0; own_over = 0; own_closed = 0;
      end
      if (own_n < NV) begin
        own_x[own_n] = x; own_y[own_n] = y; own_n++;
      end else own_over = 1;
      if (last) own_closed = 1;
      return;
    end
    if (oth_n < NV) begin
      oth_x[oth_n] = map_row(xform[pec_pkg::CFG_XX], xform[pec_pkg::CFG_XY],
                             xform[pec_pkg::CFG_TX], x, y);
      oth_y[oth_n] = map_row(xform[pec_pkg::CFG_YX], xform[pec_pkg::CFG_YY],
                             xform[pec_pkg::CFG_TY], x, y);
      oth_n++;
    end else oth_over = 1;
    if (!last) return;
    exp_hit.insert(exp_hit.size(), edges_cross());
    exp_ovf.insert(exp_ovf.size(), own_over || oth_over);
    oth_n = 0;
    oth_over = 0;
  endfunction

  // Accepted result request
  function void check_result(bit hit, bit ovf);
    bit eh, eo;
    if (exp_hit.size() == 0) begin
      $error("unexpected result: hit=%0b overflow=%0b", hit, ovf);
      errors++;
      return;
    end
    eh = exp_hit.pop_front();
    eo = exp_ovf.pop_front();
    if (hit !== eh) begin
      $error("hit mismatch: expected %0b, actual %0b", eh, hit);
      errors++;
    end
    if (ovf !== eo) begin
      $error("overflow mismatch: expected %0b, actual %0b", eo, ovf);
      errors++;
    end
  endfunction
endclass

module polygon_edge_crossing_test_tb;
  import pec_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int ONE = 65536;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_ready;
  logic in_polygon_select = 0;
  logic signed [31:0] in_vertex_x = '0;
  logic signed [31:0] in_vertex_y = '0;
  logic in_last_vertex = 0;
  logic out_valid;
  logic out_ready = 0;
  logic out_hit, out_overflow;

  crossing_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit hold_go = 0;
  int cycles = 0;
  int sent = 0;

  polygon_edge_crossing_test DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_polygon_select(in_polygon_select), .in_vertex_x(in_vertex_x),
    .in_vertex_y(in_vertex_y), .in_last_vertex(in_last_vertex),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_overflow(out_overflow)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check accepted requests, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_hit, out_overflow);
    if (hold_go) begin
      hold_left = 2500;
      hold_go = 0;
    end
    if (!rst_n) out_ready <= 0;
    else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_vertex(bit sel, logic signed [31:0] x, logic signed [31:0] y,
                             bit last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_polygon_select <= sel;
    in_vertex_x <= x;
    in_vertex_y <= y;
    in_last_vertex <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_vertex(sel, x, y, last);
    sent++;
  endtask

  // Lets the block drain before a register write
  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic load_xform(logic [31:0] xx, logic [31:0] xy, logic [31:0] tx,
                            logic [31:0] yx, logic [31:0] yy, logic [31:0] ty);
    logic [31:0] vals [6];
    vals = '{xx, xy, tx, yx, yy, ty};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(i, vals[i]);
    end
    cfg_we <= 0;
  endtask

  // Mostly small coordinates so edges meet; sometimes any 32-bit value
  function automatic logic signed [31:0] coord();
    if ($urandom_range(99) < 80) return $signed($urandom_range(0, 16 * ONE)) - 8 * ONE;
    return $urandom;
  endfunction

  function automatic int poly_size();
    if ($urandom_range(99) < 5) return $urandom_range(17, 19);
    return $urandom_range(1, 6);
  endfunction

  task automatic send_polygon(bit sel, int n);
    for (int k = 0; k < n; k++) send_vertex(sel, coord(), coord(), k == n - 1);
  endtask

  task automatic random_part(int count);
    int stop;
    stop = sent + count;
    while (sent < stop) begin
      if ($urandom_range(99) < 10)
        send_vertex(1'($urandom_range(1)), coord(), coord(), 1'($urandom_range(1)));
      else begin
        if ($urandom_range(99) < 40) send_polygon(0, poly_size());
        send_polygon(1, poly_size());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    load_xform(ONE, 0, 0, 0, ONE, 0);

    // Directed: square crossed by a triangle
    send_vertex(0, 0, 0, 0);
    send_vertex(0, 4 * ONE, 0, 0);
    send_vertex(0, 4 * ONE, 4 * ONE, 0);
    send_vertex(0, 0, 4 * ONE, 1);
    send_vertex(1, 2 * ONE, 2 * ONE, 0);
    send_vertex(1, 6 * ONE, 2 * ONE, 0);
    send_vertex(1, 6 * ONE, 6 * ONE, 1);
    // single vertex: degenerate edge
    send_vertex(1, ONE, ONE, 1);
    // segment parallel to the bottom edge, outside
    send_vertex(1, 0, -ONE, 0);
    send_vertex(1, 4 * ONE, -ONE, 1);
    // triangle wholly inside the square
    send_vertex(1, ONE, ONE, 0);
    send_vertex(1, 2 * ONE, ONE, 0);
    send_vertex(1, ONE, 2 * ONE, 1);
    // extreme coordinates
    send_vertex(1, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_vertex(1, 32'sh80000000, 32'sh80000000, 0);
    send_vertex(1, 32'sh80000000, 32'sh7fffffff, 1);
    // new own polygon, left open, at the extremes
    send_vertex(0, 32'sh80000000, 32'sh80000000, 0);
    send_vertex(0, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_vertex(1, 32'sh80000000, 32'sh7fffffff, 0);
    send_vertex(1, 32'sh7fffffff, 32'sh80000000, 1);
    // own left incomplete, then an empty-own style single pair
    send_vertex(0, -1, 0, 0);
    send_vertex(1, 0, -1, 1);

    // Phase: no idling
    random_part(130);

    wait_idle();
    load_xform(0, -ONE, 3 * ONE, ONE, 0, -2 * ONE);
    send_idle_pct = 55;
    hold_go = 1;
    random_part(140);

    wait_idle();
    load_xform(ONE / 2, ONE / 4, -ONE, -ONE / 4, 2 * ONE, ONE);
    send_idle_pct = 0;
    recv_stall_pct = 55;
    random_part(140);

    wait_idle();
    load_xform(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
               32'h80000000, 32'h80000000, 32'h80000000);
    send_idle_pct = 8;
    recv_stall_pct = 8;
    random_part(80);

    wait_idle();
    load_xform($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_part(40);

    wait_idle();
    load_xform(ONE, 0, 0, 0, ONE, 0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_part(100);

    in_valid <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
